// ----- src/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants and types for the closest timestamp search block.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 56;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // request kinds
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // search sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_LAST  = 6'b000100,
        S_MID   = 6'b001000,
        S_NBR   = 6'b010000,
        S_NEAR  = 6'b100000
    } t_state;

endpackage

// ----- src/cts_ram.sv -----
// ----------------------------------------------------------------------------
// cts_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/closest_timestamp_search.sv -----
// ----------------------------------------------------------------------------
// closest_timestamp_search
// Ascending timestamp table with append and nearest-entry binary search.
// ----------------------------------------------------------------------------
// Sequence: an append, or a query on an empty table, is finished while
//   idle, and its result is registered as the request is taken. A query
//   checks the first entry, then the last entry, then runs search steps
//   that each read the mid entry of the table RAM and, where needed, its
//   neighbour, and ends with the nearer-neighbour pick in S_NEAR.
// Throughput: one request at a time; the table RAM read port sets the pace.
// Reset: synchronous, active low; empties the table (count to zero), the
//   RAM contents are left as they are.
// ----------------------------------------------------------------------------
module closest_timestamp_search (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req_type,
    input  logic [cts_pkg::KEY_W-1:0] i_key_time,
    // result channel
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [cts_pkg::IDX_W-1:0] o_match_index,
    output logic [1:0]                o_status
);

    localparam int KW = cts_pkg::KEY_W;
    localparam int IW = cts_pkg::IDX_W;
    localparam int CW = cts_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(cts_pkg::TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    cts_pkg::t_state  r_state,      n_state;
    logic [CW-1:0]    r_count,      n_count;
    logic [KW-1:0]    r_key,        n_key;
    logic [CW-1:0]    r_lo,         n_lo;
    logic [CW-1:0]    r_hi,         n_hi;
    logic [IW-1:0]    r_mid,        n_mid;
    logic [KW-1:0]    r_mid_val,    n_mid_val;
    logic             r_nbr_lower,  n_nbr_lower;  // neighbour read is mid - 1
    logic [KW-1:0]    r_diff_lo,    n_diff_lo;    // key minus lower entry
    logic [KW-1:0]    r_diff_hi,    n_diff_hi;    // upper entry minus key
    logic             r_out_valid,  n_out_valid;
    logic [IW-1:0]    r_out_idx,    n_out_idx;
    cts_pkg::t_status r_out_status, n_out_status;

    // ------------------------------------------------------------------
    // Table RAM
    // ------------------------------------------------------------------
    logic          wr_en;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [KW-1:0] rd_data;

    cts_ram #(
        .WIDTH (KW),
        .DEPTH (cts_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (i_key_time),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Handshake
    // Take a new request only when the sequencer is idle and the result
    // register is free, or is being emptied in this cycle. Appends write
    // the RAM while idle and reads are issued only for queries, so a read
    // never overlaps a write to the same entry.
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_acc;

    assign o_ready = (r_state == cts_pkg::S_IDLE) && (!r_out_valid || i_ready);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_out_valid && i_ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic             fin;
    logic [IW-1:0]    fin_idx;
    cts_pkg::t_status fin_status;
    logic             loop_go;
    logic [CW-1:0]    lo_next;
    logic [CW-1:0]    hi_next;
    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid_ext;
    logic [CW-1:0]    mid_plus;

    assign mid_ext  = {1'b0, r_mid};
    assign mid_plus = mid_ext + CW'(1);
    assign mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_key        = r_key;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_mid_val    = r_mid_val;
        n_nbr_lower  = r_nbr_lower;
        n_diff_lo    = r_diff_lo;
        n_diff_hi    = r_diff_hi;
        n_out_valid  = r_out_valid;
        n_out_idx    = r_out_idx;
        n_out_status = r_out_status;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        fin          = 1'b0;
        fin_idx      = '0;
        fin_status   = cts_pkg::ST_OK;
        loop_go      = 1'b0;
        lo_next      = r_lo;
        hi_next      = r_hi;

        case (r_state)
            cts_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_key = i_key_time;
                    if (i_req_type == cts_pkg::REQ_APPEND) begin
                        fin = 1'b1;
                        if (r_count == DEPTH_C) begin
                            fin_status = cts_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            fin_idx = r_count[IW-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        fin        = 1'b1;
                        fin_status = cts_pkg::ST_EMPTY;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = cts_pkg::S_FIRST;
                    end
                end
            end
            cts_pkg::S_FIRST: begin
                if (r_key <= rd_data) begin
                    fin = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(r_count - CW'(1));
                    n_state = cts_pkg::S_LAST;
                end
            end
            cts_pkg::S_LAST: begin
                if (r_key >= rd_data) begin
                    fin     = 1'b1;
                    fin_idx = IW'(r_count - CW'(1));
                end else begin
                    lo_next = '0;
                    hi_next = r_count;
                    loop_go = 1'b1;
                end
            end
            cts_pkg::S_MID: begin
                n_mid_val = rd_data;
                if (rd_data == r_key) begin
                    fin     = 1'b1;
                    fin_idx = r_mid;
                end else if (r_key < rd_data) begin
                    n_nbr_lower = 1'b1;
                    if (r_mid != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = r_mid - IW'(1);
                        n_state = cts_pkg::S_NBR;
                    end else begin
                        hi_next = mid_ext;
                        loop_go = 1'b1;
                    end
                end else begin
                    n_nbr_lower = 1'b0;
                    if (mid_plus < r_count) begin
                        rd_en   = 1'b1;
                        rd_addr = IW'(mid_plus);
                        n_state = cts_pkg::S_NBR;
                    end else begin
                        lo_next = mid_plus;
                        loop_go = 1'b1;
                    end
                end
            end
            cts_pkg::S_NBR: begin
                if (r_nbr_lower) begin
                    if (r_key > rd_data) begin
                        n_diff_lo = r_key - rd_data;
                        n_diff_hi = r_mid_val - r_key;
                        n_state   = cts_pkg::S_NEAR;
                    end else begin
                        hi_next = mid_ext;
                        loop_go = 1'b1;
                    end
                end else begin
                    if (r_key < rd_data) begin
                        n_diff_lo = r_key - r_mid_val;
                        n_diff_hi = rd_data - r_key;
                        n_state   = cts_pkg::S_NEAR;
                    end else begin
                        lo_next = mid_plus;
                        loop_go = 1'b1;
                    end
                end
            end
            cts_pkg::S_NEAR: begin
                // a tie goes to the upper neighbour
                fin = 1'b1;
                if (r_diff_lo >= r_diff_hi) begin
                    fin_idx = r_nbr_lower ? r_mid : IW'(mid_plus);
                end else begin
                    fin_idx = r_nbr_lower ? (r_mid - IW'(1)) : r_mid;
                end
            end
            default: begin
                n_state = cts_pkg::S_IDLE;
            end
        endcase

        // advance the search window, or finish on the last mid
        if (loop_go) begin
            n_lo = lo_next;
            n_hi = hi_next;
            if (lo_next < hi_next) begin
                n_mid   = mid_sum[IW:1];
                rd_en   = 1'b1;
                rd_addr = mid_sum[IW:1];
                n_state = cts_pkg::S_MID;
            end else begin
                fin     = 1'b1;
                fin_idx = r_mid;
            end
        end

        if (out_acc) begin
            n_out_valid = 1'b0;
        end
        if (fin) begin
            n_state      = cts_pkg::S_IDLE;
            n_out_valid  = 1'b1;
            n_out_idx    = fin_idx;
            n_out_status = fin_status;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cts_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_mid_val    <= n_mid_val;
        r_nbr_lower  <= n_nbr_lower;
        r_diff_lo    <= n_diff_lo;
        r_diff_hi    <= n_diff_hi;
        r_out_idx    <= n_out_idx;
        r_out_status <= n_out_status;
    end

    assign o_valid       = r_out_valid;
    assign o_match_index = r_out_idx;
    assign o_status      = r_out_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == cts_pkg::REQ_APPEND && r_count != DEPTH_C)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not advance the entry count");

    a_mid_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cts_pkg::S_MID) |-> (r_lo < r_hi && mid_ext < r_count))
        else $error("search probe outside the live window");

    a_result_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == cts_pkg::ST_OK)
        |-> ({1'b0, r_out_idx} < r_count))
        else $error("ok result points past the last entry");

endmodule

// ----- test/closest_timestamp_search_tb.sv -----
// ----------------------------------------------------------------------------
// closest_timestamp_search_tb
// Self-checking bench for the timestamp table. Appends and nearest-entry
// queries are driven over valid/ready with random gaps on both sides. Each
// taken request is scored by a local copy of the table and search, and each
// result is checked against the oldest outstanding prediction. The run grows
// the table from empty to several hundred entries, including out-of-order
// appends.
// ----------------------------------------------------------------------------
module closest_timestamp_search_tb;

    typedef struct packed {
        logic                      kind;
        logic [cts_pkg::KEY_W-1:0] key;
    } t_stamp_req;

    typedef struct packed {
        logic [cts_pkg::IDX_W-1:0] slot;
        cts_pkg::t_status          status;
    } t_match;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_valid    = 1'b0;
    logic                      i_req_type = cts_pkg::REQ_APPEND;
    logic [cts_pkg::KEY_W-1:0] i_key_time = '0;
    logic                      i_ready    = 1'b0;
    logic                      o_ready;
    logic                      o_valid;
    logic [cts_pkg::IDX_W-1:0] o_match_index;
    logic [1:0]                o_status;

    closest_timestamp_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_key_time    (i_key_time),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_index (o_match_index),
        .o_status      (o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Requests waiting to be driven, and matches waiting to come back
    // ------------------------------------------------------------------
    t_stamp_req                request_queue[$];
    t_match                    expected_matches[$];

    // stimulus-side view of what has been stored, used to aim queries
    logic [cts_pkg::KEY_W-1:0] stamps_sent[$];
    logic [cts_pkg::KEY_W-1:0] last_stamp = '0;

    // scoring copy of the table
    logic [cts_pkg::KEY_W-1:0] ts_table [cts_pkg::TABLE_DEPTH];
    logic [cts_pkg::CNT_W-1:0] ts_count = '0;

    int mismatch_count = 0;
    int appends_taken  = 0;
    int full_rejects   = 0;
    int queries_taken  = 0;
    int empty_queries  = 0;

    logic req_fire = 1'b0;
    logic res_fire = 1'b0;
    int   src_gap  = 0;
    int   src_calm = 0;
    int   snk_gap  = 0;
    int   snk_calm = 0;

    // ------------------------------------------------------------------
    // Scoring model
    // ------------------------------------------------------------------
    // pick the nearer of two neighbours; a tie goes to the higher index
    function automatic logic [cts_pkg::IDX_W-1:0] nearer_slot(
            int lo_i, int hi_i, logic [cts_pkg::KEY_W-1:0] key);
        logic [cts_pkg::KEY_W-1:0] below;
        logic [cts_pkg::KEY_W-1:0] above;
        below = key - ts_table[lo_i];
        above = ts_table[hi_i] - key;
        return (below >= above) ? cts_pkg::IDX_W'(hi_i) : cts_pkg::IDX_W'(lo_i);
    endfunction

    function automatic logic [cts_pkg::IDX_W-1:0] nearest_slot(
            logic [cts_pkg::KEY_W-1:0] key);
        int n;
        int lo;
        int hi;
        int mid;
        n   = ts_count;
        lo  = 0;
        hi  = n;
        mid = 0;
        if (key <= ts_table[0])
            return '0;
        if (key >= ts_table[n-1])
            return cts_pkg::IDX_W'(n - 1);
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (ts_table[mid] == key)
                return cts_pkg::IDX_W'(mid);
            if (key < ts_table[mid]) begin
                if (mid > 0 && key > ts_table[mid-1])
                    return nearer_slot(mid - 1, mid, key);
                hi = mid;
            end else begin
                if (mid + 1 < n && key < ts_table[mid+1])
                    return nearer_slot(mid, mid + 1, key);
                lo = mid + 1;
            end
        end
        return cts_pkg::IDX_W'(mid);
    endfunction

    // apply one taken request to the scoring table and return its result
    function automatic t_match serve_request(logic kind,
                                             logic [cts_pkg::KEY_W-1:0] key);
        t_match r;
        r.slot   = '0;
        r.status = cts_pkg::ST_OK;
        if (kind == cts_pkg::REQ_APPEND) begin
            if (ts_count >= cts_pkg::TABLE_DEPTH) begin
                r.status = cts_pkg::ST_FULL;
                full_rejects++;
            end else begin
                ts_table[ts_count[cts_pkg::IDX_W-1:0]] = key;
                r.slot   = ts_count[cts_pkg::IDX_W-1:0];
                ts_count = ts_count + 1'b1;
                appends_taken++;
            end
        end else if (ts_count == 0) begin
            r.status = cts_pkg::ST_EMPTY;
            empty_queries++;
        end else begin
            r.slot = nearest_slot(key);
            queries_taken++;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [cts_pkg::KEY_W-1:0] any_stamp();
        logic [31:0] hi_w;
        logic [31:0] lo_w;
        hi_w = $urandom();
        lo_w = $urandom();
        return {hi_w[cts_pkg::KEY_W-33:0], lo_w};
    endfunction

    // advance the ascending timestamp, saturating at the top of the range
    function automatic logic [cts_pkg::KEY_W-1:0] next_stamp();
        logic [cts_pkg::KEY_W:0]   sum;
        logic [cts_pkg::KEY_W-1:0] step;
        logic [31:0]               hi_w;
        int                        r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            step = '0;
        end else if (r < 50) begin
            step = cts_pkg::KEY_W'($urandom_range(1, 15));
        end else if (r < 85) begin
            step = cts_pkg::KEY_W'($urandom_range(16, 1 << 20));
        end else begin
            hi_w = $urandom_range(0, 4095);
            step = cts_pkg::KEY_W'({hi_w[11:0], 32'($urandom())});
        end
        sum = {1'b0, last_stamp} + {1'b0, step};
        return sum[cts_pkg::KEY_W] ? '1 : sum[cts_pkg::KEY_W-1:0];
    endfunction

    // aim a query at, near, between or outside the stored entries
    function automatic logic [cts_pkg::KEY_W-1:0] query_key();
        int                        n;
        int                        i;
        int                        r;
        logic [cts_pkg::KEY_W-1:0] base;
        logic [cts_pkg::KEY_W-1:0] upper;
        n    = stamps_sent.size();
        i    = $urandom_range(0, n - 1);
        r    = $urandom_range(0, 99);
        base = stamps_sent[i];
        if (r < 30)
            return base;
        if (r < 50) begin
            if ($urandom_range(0, 1) == 1 && base != '1)
                return base + $urandom_range(1, 3);
            if (base >= 3)
                return base - $urandom_range(1, 3);
            return base + 1'b1;
        end
        if (r < 70 && n > 1) begin
            i     = $urandom_range(0, n - 2);
            base  = stamps_sent[i];
            upper = stamps_sent[i+1];
            // midpoint lands on a tie when the spacing is even
            return base + (upper - base) / 2 + $urandom_range(0, 1);
        end
        if (r < 80)
            return ($urandom_range(0, 1) == 1) ? '0 : stamps_sent[0];
        if (r < 90)
            return ($urandom_range(0, 1) == 1) ? '1 : stamps_sent[n-1];
        return any_stamp();
    endfunction

    task automatic queue_request(logic kind, logic [cts_pkg::KEY_W-1:0] key);
        t_stamp_req q;
        q.kind = kind;
        q.key  = key;
        request_queue = {request_queue, q};
        if (kind == cts_pkg::REQ_APPEND && stamps_sent.size() < cts_pkg::TABLE_DEPTH)
            stamps_sent = {stamps_sent, key};
    endtask

    task automatic queue_append_next();
        // pin the last few entries to the top of the range
        if (stamps_sent.size() >= cts_pkg::TABLE_DEPTH - 3)
            last_stamp = '1;
        else
            last_stamp = next_stamp();
        queue_request(cts_pkg::REQ_APPEND, last_stamp);
    endtask

    // ------------------------------------------------------------------
    // Request driver: change on the falling edge, hold until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_stamp_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_fire) begin
            // hold the request until the block takes it
        end else if (src_gap > 0) begin
            i_valid <= 1'b0;
            src_gap <= src_gap - 1;
        end else if (request_queue.size() > 0) begin
            nxt = request_queue.pop_front();
            i_valid    <= 1'b1;
            i_req_type <= nxt.kind;
            i_key_time <= nxt.key;
            if (src_calm > 0) begin
                src_gap  <= 0;
                src_calm <= src_calm - 1;
            end else begin
                src_gap <= pick_idle();
                if ($urandom_range(0, 31) == 0)
                    src_calm <= $urandom_range(10, 40);
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result-side back-pressure
    always @(negedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (snk_gap > 0) begin
            i_ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end else if (res_fire) begin
            if (snk_calm > 0) begin
                stall    = 0;
                snk_calm <= snk_calm - 1;
            end else begin
                stall = pick_idle();
                if ($urandom_range(0, 31) == 0)
                    snk_calm <= $urandom_range(10, 40);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                snk_gap <= stall - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, score requests, check results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_match want;
        req_fire <= i_rst_n && i_valid && o_ready;
        res_fire <= i_rst_n && o_valid && i_ready;
        // check before predicting so a same-edge request never matches
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_matches.size() == 0) begin
                report_mismatch($sformatf("unexpected result index %0d status %0d",
                                          o_match_index, o_status));
            end else begin
                want = expected_matches.pop_front();
                if (o_match_index !== want.slot)
                    report_mismatch($sformatf("match_index %0d, expected %0d",
                                              o_match_index, want.slot));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
            end
        end
        if (i_rst_n && i_valid && o_ready)
            expected_matches = {expected_matches,
                                serve_request(i_req_type, i_key_time)};
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int k;

        // empty table, then a small hand-made table
        queue_request(cts_pkg::REQ_QUERY, '0);
        queue_request(cts_pkg::REQ_QUERY, '1);
        queue_request(cts_pkg::REQ_APPEND, 56'd100);
        queue_request(cts_pkg::REQ_APPEND, 56'd200);
        queue_request(cts_pkg::REQ_APPEND, 56'd300);
        queue_request(cts_pkg::REQ_APPEND, 56'd400);
        queue_request(cts_pkg::REQ_APPEND, 56'd1000);
        queue_request(cts_pkg::REQ_QUERY, '0);          // below first entry
        queue_request(cts_pkg::REQ_QUERY, 56'd100);     // equal to first entry
        queue_request(cts_pkg::REQ_QUERY, 56'd5000);    // above last entry
        queue_request(cts_pkg::REQ_QUERY, '1);          // top of range
        queue_request(cts_pkg::REQ_QUERY, 56'd200);     // exact hit inside
        queue_request(cts_pkg::REQ_QUERY, 56'd250);     // tie, higher index wins
        queue_request(cts_pkg::REQ_QUERY, 56'd240);     // nearer to lower neighbour
        queue_request(cts_pkg::REQ_QUERY, 56'd260);     // nearer to upper neighbour
        queue_request(cts_pkg::REQ_QUERY, 56'd700);     // tie across a wide gap
        queue_request(cts_pkg::REQ_QUERY, 56'd699);
        queue_request(cts_pkg::REQ_APPEND, 56'd1000);   // duplicate timestamp
        queue_request(cts_pkg::REQ_QUERY, 56'd1000);
        queue_request(cts_pkg::REQ_QUERY, 56'd300);
        last_stamp = 56'd1000;

        // mixed traffic over a growing table, with a few out-of-order appends
        for (k = 0; k < 780; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 99) < 2)
                    queue_request(cts_pkg::REQ_APPEND, any_stamp());
                else
                    queue_append_next();
            end else begin
                queue_request(cts_pkg::REQ_QUERY, query_key());
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || i_valid || expected_matches.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d appends, %0d rejected on a full table, %0d searches, %0d on empty",
                 appends_taken, full_rejects, queries_taken, empty_queries);
        $display("final table size %0d, %0d mismatches", ts_count, mismatch_count);
        if (mismatch_count == 0 && expected_matches.size() == 0) begin
            $display("closest_timestamp_search_tb OK");
        end else begin
            $display("closest_timestamp_search_tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("timeout with %0d results outstanding", expected_matches.size());
        $display("closest_timestamp_search_tb NOT OK");
        $finish;
    end

endmodule

// ----- closest_timestamp_search.f -----
src/cts_pkg.sv
src/cts_ram.sv
src/closest_timestamp_search.sv
test/closest_timestamp_search_tb.sv
